// File: src/gfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfs_pkg
// Shared types and constants of the grayscale frame statistics block.
// ----------------------------------------------------------------------------
package gfs_pkg;

	localparam int PIXEL_W    = 8;
	localparam int RUN_W      = 11;
	localparam int ASYM_W     = 11;
	localparam int CONTRAST_W = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int TDATA_IN_W  = 8;
	localparam int TDATA_OUT_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST_THRESHOLD = 2'd2;

	localparam logic [9:0]         WIDTH_RESET     = 10'd320;
	localparam logic [10:0]        HEIGHT_RESET    = 11'd200;
	localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd128;
	localparam logic [PIXEL_W-1:0] DARKEST_RESET   = 8'd255;
	localparam logic [RUN_W-1:0]   RUN_MAX         = 11'd2047;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_LW    = QUEUE_AW + 1;

	typedef struct packed {
		logic valid;
		logic has_left;
		logic has_above;
		logic last_col;
		logic last_row;
		logic mirror_en;
	} s1_ctrl_t;

	typedef struct packed {
		logic prev_en;
		logic prev_val;
		logic last_en;
		logic last_val;
	} flag_wr_t;

	typedef struct packed {
		logic [RUN_W-1:0]      longest_vertical_run;
		logic [CONTRAST_W-1:0] contrast_pixels;
		logic [ASYM_W-1:0]     asymmetric_rows;
		logic [PIXEL_W-1:0]    darkest;
		logic [PIXEL_W-1:0]    brightest;
	} result_t;

endpackage

// File: src/gfs_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfs_store
// Column stores: previous-row pixels, column run lengths and pending contrast
// flags, with last-write forwarding for back-to-back read-modify-write.
// ----------------------------------------------------------------------------
module gfs_store #(
	parameter int MAX_COLUMNS = 512
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic [$clog2(MAX_COLUMNS)-1:0]  rd_addr,
	input  logic [$clog2(MAX_COLUMNS)-1:0]  mirror_addr,
	input  logic                            wr_en,
	input  logic [$clog2(MAX_COLUMNS)-1:0]  wr_addr,
	input  logic [gfs_pkg::PIXEL_W-1:0]     wr_pixel,
	input  logic [gfs_pkg::RUN_W-1:0]       wr_run,
	input  gfs_pkg::flag_wr_t               flag_wr,
	output logic [gfs_pkg::PIXEL_W-1:0]     above_pixel,
	output logic [gfs_pkg::PIXEL_W-1:0]     mirror_pixel,
	output logic [gfs_pkg::RUN_W-1:0]       run_length,
	output logic                            pending_flag
);

	localparam int CW = $clog2(MAX_COLUMNS);

	logic [gfs_pkg::PIXEL_W-1:0] line_mem [MAX_COLUMNS];
	logic [gfs_pkg::RUN_W-1:0]   run_mem  [MAX_COLUMNS];
	logic                        flag_mem [MAX_COLUMNS];

	logic [gfs_pkg::PIXEL_W-1:0] line_rd_s1;
	logic [gfs_pkg::PIXEL_W-1:0] mirror_rd_s1;
	logic [gfs_pkg::RUN_W-1:0]   run_rd_s1;
	logic                        flag_rd_s1;
	logic [CW-1:0]               rd_addr_s1;
	logic [CW-1:0]               mirror_addr_s1;

	logic                        lw_vld_q;
	logic [CW-1:0]               lw_addr_q;
	logic [gfs_pkg::PIXEL_W-1:0] lw_pixel_q;
	logic [gfs_pkg::RUN_W-1:0]   lw_run_q;

	logic                        lw_flag_vld_q;
	logic [CW-1:0]               lw_flag_addr_q;
	logic                        lw_flag_q;

	logic                        defer_vld_q;
	logic [CW-1:0]               defer_addr_q;
	logic                        defer_val_q;

	logic                        flag_we;
	logic [CW-1:0]               flag_waddr;
	logic                        flag_wdata;

	always_comb begin
		flag_we    = flag_wr.prev_en || defer_vld_q;
		flag_waddr = flag_wr.prev_en ? (wr_addr - CW'(1)) : defer_addr_q;
		flag_wdata = flag_wr.prev_en ? flag_wr.prev_val : defer_val_q;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			line_rd_s1     <= line_mem[rd_addr];
			mirror_rd_s1   <= line_mem[mirror_addr];
			run_rd_s1      <= run_mem[rd_addr];
			flag_rd_s1     <= flag_mem[rd_addr];
			rd_addr_s1     <= rd_addr;
			mirror_addr_s1 <= mirror_addr;
		end
		if (wr_en) begin
			line_mem[wr_addr] <= wr_pixel;
			run_mem[wr_addr]  <= wr_run;
		end
		if (flag_we) begin
			flag_mem[flag_waddr] <= flag_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lw_addr_q  <= wr_addr;
			lw_pixel_q <= wr_pixel;
			lw_run_q   <= wr_run;
		end
		if (flag_we) begin
			lw_flag_addr_q <= flag_waddr;
			lw_flag_q      <= flag_wdata;
		end
		if (flag_wr.last_en) begin
			defer_addr_q <= wr_addr;
			defer_val_q  <= flag_wr.last_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_vld_q      <= 1'b0;
			lw_flag_vld_q <= 1'b0;
			defer_vld_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				lw_vld_q <= 1'b1;
			end
			if (flag_we) begin
				lw_flag_vld_q <= 1'b1;
			end
			defer_vld_q <= flag_wr.last_en;
		end
	end

	always_comb begin
		above_pixel  = (lw_vld_q && lw_addr_q == rd_addr_s1) ? lw_pixel_q : line_rd_s1;
		mirror_pixel = (lw_vld_q && lw_addr_q == mirror_addr_s1) ? lw_pixel_q : mirror_rd_s1;
		run_length   = (lw_vld_q && lw_addr_q == rd_addr_s1) ? lw_run_q : run_rd_s1;
		if (defer_vld_q && defer_addr_q == rd_addr_s1) begin
			pending_flag = defer_val_q;
		end else if (lw_flag_vld_q && lw_flag_addr_q == rd_addr_s1) begin
			pending_flag = lw_flag_q;
		end else begin
			pending_flag = flag_rd_s1;
		end
	end

endmodule

// File: src/gfs_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfs_stats
// Per-pixel update: contrast flags, column runs, mirror check and the frame
// accumulators; builds the result at the last pixel and clears for the next.
// ----------------------------------------------------------------------------
module gfs_stats (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gfs_pkg::s1_ctrl_t              ctrl,
	input  logic [gfs_pkg::PIXEL_W-1:0]    pixel,
	input  logic [gfs_pkg::PIXEL_W-1:0]    threshold,
	input  logic [gfs_pkg::PIXEL_W-1:0]    above_pixel,
	input  logic [gfs_pkg::PIXEL_W-1:0]    mirror_pixel,
	input  logic [gfs_pkg::RUN_W-1:0]      run_in,
	input  logic                           pending_flag,
	output logic [gfs_pkg::RUN_W-1:0]      wr_run,
	output gfs_pkg::flag_wr_t              flag_wr,
	output logic                           emit,
	output gfs_pkg::result_t               result
);

	logic [gfs_pkg::PIXEL_W-1:0]    left_pixel_q;
	logic                           left_flag_q;
	logic [gfs_pkg::PIXEL_W-1:0]    max_q;
	logic [gfs_pkg::PIXEL_W-1:0]    min_q;
	logic                           mismatch_q;
	logic [gfs_pkg::ASYM_W-1:0]     asym_q;
	logic [gfs_pkg::CONTRAST_W-1:0] contrast_q;
	logic [gfs_pkg::RUN_W-1:0]      best_q;

	logic                           up_c;
	logic                           left_c;
	logic                           own;
	logic                           left_f;
	logic [1:0]                     inc;
	logic                           mis;
	logic [gfs_pkg::PIXEL_W-1:0]    max_next;
	logic [gfs_pkg::PIXEL_W-1:0]    min_next;
	logic [gfs_pkg::ASYM_W-1:0]     asym_next;
	logic [gfs_pkg::CONTRAST_W-1:0] contrast_next;
	logic [gfs_pkg::RUN_W-1:0]      best_next;

	function automatic logic differs(input logic [gfs_pkg::PIXEL_W-1:0] a,
		input logic [gfs_pkg::PIXEL_W-1:0] b, input logic [gfs_pkg::PIXEL_W-1:0] thr);
		logic [gfs_pkg::PIXEL_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return d > thr;
	endfunction

	always_comb begin
		up_c   = ctrl.has_above && differs(pixel, above_pixel, threshold);
		left_c = ctrl.has_left && differs(pixel, left_pixel_q, threshold);
		own    = up_c || left_c;
		left_f = left_flag_q || left_c;
		inc    = {1'b0, ctrl.has_above && (pending_flag || up_c)}
		       + {1'b0, ctrl.has_left && ctrl.last_row && left_f}
		       + {1'b0, ctrl.last_col && ctrl.last_row && own};

		flag_wr.prev_en  = ctrl.valid && ctrl.has_left && !ctrl.last_row;
		flag_wr.prev_val = left_f;
		flag_wr.last_en  = ctrl.valid && ctrl.last_col && !ctrl.last_row;
		flag_wr.last_val = own;

		if (ctrl.has_above && pixel == above_pixel) begin
			wr_run = (run_in == gfs_pkg::RUN_MAX) ? gfs_pkg::RUN_MAX
			                                      : (run_in + gfs_pkg::RUN_W'(1));
		end else begin
			wr_run = gfs_pkg::RUN_W'(1);
		end

		mis           = ctrl.mirror_en && pixel != mirror_pixel;
		max_next      = (pixel > max_q) ? pixel : max_q;
		min_next      = (pixel < min_q) ? pixel : min_q;
		asym_next     = asym_q + gfs_pkg::ASYM_W'(ctrl.last_col && (mismatch_q || mis));
		contrast_next = contrast_q + gfs_pkg::CONTRAST_W'(inc);
		best_next     = (wr_run > best_q) ? wr_run : best_q;

		emit                        = ctrl.valid && ctrl.last_col && ctrl.last_row;
		result.brightest            = max_next;
		result.darkest              = min_next;
		result.asymmetric_rows      = asym_next;
		result.contrast_pixels      = contrast_next;
		result.longest_vertical_run = best_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_pixel_q <= '0;
			left_flag_q  <= 1'b0;
			max_q        <= '0;
			min_q        <= gfs_pkg::DARKEST_RESET;
			mismatch_q   <= 1'b0;
			asym_q       <= '0;
			contrast_q   <= '0;
			best_q       <= '0;
		end else if (ctrl.valid) begin
			if (emit) begin
				left_pixel_q <= '0;
				left_flag_q  <= 1'b0;
				max_q        <= '0;
				min_q        <= gfs_pkg::DARKEST_RESET;
				mismatch_q   <= 1'b0;
				asym_q       <= '0;
				contrast_q   <= '0;
				best_q       <= '0;
			end else begin
				left_pixel_q <= pixel;
				left_flag_q  <= ctrl.last_col ? 1'b0 : own;
				max_q        <= max_next;
				min_q        <= min_next;
				mismatch_q   <= ctrl.last_col ? 1'b0 : (mismatch_q || mis);
				asym_q       <= asym_next;
				contrast_q   <= contrast_next;
				best_q       <= best_next;
			end
		end
	end

endmodule

// File: src/gfs_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfs_out_queue
// Small result queue between the statistics stage and the output stream.
// ----------------------------------------------------------------------------
module gfs_out_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  gfs_pkg::result_t              push_data,
	output logic                          tvalid,
	input  logic                          tready,
	output gfs_pkg::result_t              tdata,
	output logic [gfs_pkg::QUEUE_LW-1:0]  level
);

	gfs_pkg::result_t                entries_q [gfs_pkg::QUEUE_DEPTH];
	logic [gfs_pkg::QUEUE_AW-1:0]    wr_ptr_q;
	logic [gfs_pkg::QUEUE_AW-1:0]    rd_ptr_q;
	logic [gfs_pkg::QUEUE_LW-1:0]    level_q;
	logic                            pop;

	assign tvalid = level_q != '0;
	assign tdata  = entries_q[rd_ptr_q];
	assign level  = level_q;
	assign pop    = tvalid && tready;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + gfs_pkg::QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + gfs_pkg::QUEUE_AW'(1);
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + gfs_pkg::QUEUE_LW'(1);
				2'b01:   level_q <= level_q - gfs_pkg::QUEUE_LW'(1);
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

// File: src/grayscale_frame_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grayscale_frame_statistics
// Frame statistics of an 8-bit grayscale raster stream: brightest and darkest
// value, asymmetric rows, contrasting pixels and longest vertical run.
// ----------------------------------------------------------------------------
// Pixels enter on the s_axis channel in raster order, one per transaction,
// for a frame of frame_width by frame_height set through the cfg port
// (index 0 width, 1 height, 2 contrast threshold; write only between
// frames or while no transaction is in flight).
// Each pixel passes an accept stage that issues the column store reads and
// an update stage that updates and writes back the column stores.
// Back-to-back pixels to the same column entry are served by forwarding of
// the last write, so the block takes one pixel per clock while s_axis_tready stays high.
// After the last pixel of a frame its result passes the stage registers and is
// pushed into the result queue, whose head drives m_axis.
// Results wait in a four-entry queue; s_axis_tready drops while three results
// are queued or being pushed, which needs tiny frames and a stalled receiver.
// Reset restores the register defaults (320 x 200, threshold 128) and clears
// all counters; the column stores need no clearing pass, each entry is
// written by the first row before it is read.
// ----------------------------------------------------------------------------
module grayscale_frame_statistics #(
	parameter int MAX_COLUMNS = 512,
	parameter int MAX_ROWS    = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [gfs_pkg::TDATA_IN_W-1:0]     s_axis_tdata,  // [7:0] pixel
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [7:0] brightest, [15:8] darkest, [26:16] asymmetric_rows,
	// [46:27] contrast_pixels, [57:47] longest_vertical_run, [63:58] zero
	output logic [gfs_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
	input  logic                               cfg_we,
	input  logic [gfs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gfs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int LW = ((CW > 10) ? CW : 10) + 1;
	localparam int LH = ((RW > 11) ? RW : 11) + 1;
	localparam int RES_W = $bits(gfs_pkg::result_t);

	logic [9:0]                    frame_width_q;
	logic [10:0]                   frame_height_q;
	logic [gfs_pkg::PIXEL_W-1:0]   threshold_q;

	logic [CW-1:0]                 col_q;
	logic [RW-1:0]                 row_q;

	logic [LW-1:0]                 fw_ext;
	logic [LH-1:0]                 fh_ext;
	logic [CW-1:0]                 wm1;
	logic [RW-1:0]                 hm1;
	logic                          last_col;
	logic                          last_row;
	logic                          mirror_en;
	logic [CW-1:0]                 mirror_addr;
	logic                          acc;

	gfs_pkg::s1_ctrl_t             ctrl_s1;
	logic [gfs_pkg::PIXEL_W-1:0]   pixel_s1;
	logic [CW-1:0]                 col_s1;

	logic [gfs_pkg::PIXEL_W-1:0]   above_pixel;
	logic [gfs_pkg::PIXEL_W-1:0]   mirror_pixel;
	logic [gfs_pkg::RUN_W-1:0]     run_length;
	logic                          pending_flag;
	logic [gfs_pkg::RUN_W-1:0]     wr_run;
	gfs_pkg::flag_wr_t             flag_wr;
	logic                          emit;
	gfs_pkg::result_t              result;
	gfs_pkg::result_t              out_result;
	logic [gfs_pkg::QUEUE_LW-1:0]  q_level;

	always_comb begin
		fw_ext = LW'(frame_width_q);
		fh_ext = LH'(frame_height_q);
		if (frame_width_q == '0) begin
			wm1 = '0;
		end else if (fw_ext > LW'(MAX_COLUMNS)) begin
			wm1 = CW'(MAX_COLUMNS - 1);
		end else begin
			wm1 = CW'(fw_ext - LW'(1));
		end
		if (frame_height_q == '0) begin
			hm1 = '0;
		end else if (fh_ext > LH'(MAX_ROWS)) begin
			hm1 = RW'(MAX_ROWS - 1);
		end else begin
			hm1 = RW'(fh_ext - LH'(1));
		end
		last_col    = col_q >= wm1;
		last_row    = row_q >= hm1;
		mirror_en   = (col_q <= wm1) && ({col_q, 1'b0} > {1'b0, wm1});
		mirror_addr = wm1 - col_q;
	end

	assign s_axis_tready = (q_level + gfs_pkg::QUEUE_LW'(emit))
	                       <= gfs_pkg::QUEUE_LW'(gfs_pkg::QUEUE_DEPTH - 2);
	assign acc = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= gfs_pkg::WIDTH_RESET;
			frame_height_q <= gfs_pkg::HEIGHT_RESET;
			threshold_q    <= gfs_pkg::THRESHOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				gfs_pkg::CFG_FRAME_WIDTH:        frame_width_q  <= cfg_data[9:0];
				gfs_pkg::CFG_FRAME_HEIGHT:       frame_height_q <= cfg_data[10:0];
				gfs_pkg::CFG_CONTRAST_THRESHOLD: threshold_q    <= cfg_data[7:0];
				default:                         threshold_q    <= threshold_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid     <= acc;
			ctrl_s1.has_left  <= col_q != '0;
			ctrl_s1.has_above <= row_q != '0;
			ctrl_s1.last_col  <= last_col;
			ctrl_s1.last_row  <= last_row;
			ctrl_s1.mirror_en <= mirror_en;
			if (acc) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : (row_q + RW'(1));
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pixel_s1 <= s_axis_tdata[7:0];
			col_s1   <= col_q;
		end
	end

	gfs_store #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_en        (acc),
		.rd_addr      (col_q),
		.mirror_addr  (mirror_addr),
		.wr_en        (ctrl_s1.valid),
		.wr_addr      (col_s1),
		.wr_pixel     (pixel_s1),
		.wr_run       (wr_run),
		.flag_wr      (flag_wr),
		.above_pixel  (above_pixel),
		.mirror_pixel (mirror_pixel),
		.run_length   (run_length),
		.pending_flag (pending_flag)
	);

	gfs_stats u_stats (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl_s1),
		.pixel        (pixel_s1),
		.threshold    (threshold_q),
		.above_pixel  (above_pixel),
		.mirror_pixel (mirror_pixel),
		.run_in       (run_length),
		.pending_flag (pending_flag),
		.wr_run       (wr_run),
		.flag_wr      (flag_wr),
		.emit         (emit),
		.result       (result)
	);

	gfs_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (result),
		.tvalid    (m_axis_tvalid),
		.tready    (m_axis_tready),
		.tdata     (out_result),
		.level     (q_level)
	);

	assign m_axis_tdata = {{(gfs_pkg::TDATA_OUT_W - RES_W){1'b0}}, out_result};

	a_emit_at_origin: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (col_q == '0 && row_q == '0))
		else $error("result pushed while the position counters are off the frame origin");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (q_level < gfs_pkg::QUEUE_LW'(gfs_pkg::QUEUE_DEPTH)))
		else $error("result pushed into a full queue");

	a_flag_port_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_s1.valid && ctrl_s1.last_col && !ctrl_s1.last_row)
		|=> !(ctrl_s1.valid && ctrl_s1.has_left))
		else $error("deferred flag write collides with a left-neighbor flag write");

endmodule

// File: bench/frame_stats_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_stats_check_pkg
// Expected frame statistics for the grayscale frame statistics bench: a
// pixel-by-pixel model of the block's counters and line stores that queues
// one expected result per completed frame and checks results against them.
// ----------------------------------------------------------------------------
package frame_stats_check_pkg;
	import gfs_pkg::*;

	localparam int LINE_DEPTH  = 512;
	localparam int ROWS_MAX    = 1024;
	localparam int RUN_CEILING = 2047;
	localparam int STATS_W     = $bits(result_t);

	class frame_stats_scoreboard;
		logic [9:0]            width_reg;
		logic [10:0]           height_reg;
		logic [PIXEL_W-1:0]    threshold_reg;

		logic [PIXEL_W-1:0]    line_px [LINE_DEPTH];
		int                    run_len [LINE_DEPTH];
		bit                    carried_flag [LINE_DEPTH];
		logic [PIXEL_W-1:0]    left_px;
		bit                    left_flag;
		int                    col;
		int                    row;
		int                    brightest_so_far;
		int                    darkest_so_far;
		bit                    row_broken;
		logic [ASYM_W-1:0]     asym_rows;
		logic [CONTRAST_W-1:0] contrast_total;
		int                    longest_run;

		result_t               expected_stats [$];
		int                    frames_checked;
		int                    errors;

		function new();
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			threshold_reg = THRESHOLD_RESET;
			foreach (line_px[i]) begin
				line_px[i] = '0;
				run_len[i] = 0;
				carried_flag[i] = 1'b0;
			end
			start_frame();
			frames_checked = 0;
			errors = 0;
		endfunction

		function void start_frame();
			left_px = '0;
			left_flag = 1'b0;
			col = 0;
			row = 0;
			brightest_so_far = 0;
			darkest_so_far = int'(DARKEST_RESET);
			row_broken = 1'b0;
			asym_rows = '0;
			contrast_total = '0;
			longest_run = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_FRAME_WIDTH: width_reg = value[9:0];
				CFG_FRAME_HEIGHT: height_reg = value[10:0];
				CFG_CONTRAST_THRESHOLD: threshold_reg = value[PIXEL_W-1:0];
				default: ;
			endcase
		endfunction

		function int cols_in_use();
			if (width_reg == 0)
				return 1;
			if (int'(width_reg) > LINE_DEPTH)
				return LINE_DEPTH;
			return int'(width_reg);
		endfunction

		function int rows_in_use();
			if (height_reg == 0)
				return 1;
			if (int'(height_reg) > ROWS_MAX)
				return ROWS_MAX;
			return int'(height_reg);
		endfunction

		function bit exceeds(int a, int b);
			int d;
			d = a > b ? a - b : b - a;
			return d > int'(threshold_reg);
		endfunction

		function void tally(bit hit);
			if (hit)
				contrast_total++;
		endfunction

		function void absorb_pixel(logic [PIXEL_W-1:0] px);
			int cur, w, h, c, r, above, run;
			bit last_col, last_row, has_above, up_hit, left_hit, own, carry;
			result_t outcome;
			cur = int'(px);
			w = cols_in_use();
			h = rows_in_use();
			c = col >= LINE_DEPTH ? LINE_DEPTH - 1 : col;
			r = row;
			last_col = c >= w - 1;
			last_row = r >= h - 1;
			has_above = r > 0;
			above = int'(line_px[c]);

			// finish the pixel above, carry this row's flags down
			up_hit = has_above && exceeds(cur, above);
			left_hit = c > 0 && exceeds(cur, int'(left_px));
			if (has_above)
				tally(carried_flag[c] || up_hit);
			if (c > 0) begin
				carry = left_flag || left_hit;
				if (last_row)
					tally(carry);
				else
					carried_flag[c - 1] = carry;
			end
			own = up_hit || left_hit;
			if (last_col) begin
				if (last_row)
					tally(own);
				else
					carried_flag[c] = own;
				left_flag = 1'b0;
			end else begin
				left_flag = own;
			end

			if (has_above && cur == above) begin
				run = run_len[c];
				if (run < RUN_CEILING)
					run++;
			end else begin
				run = 1;
			end
			run_len[c] = run;
			if (run > longest_run)
				longest_run = run;

			if (c < w && 2 * c > w - 1 && px != line_px[w - 1 - c])
				row_broken = 1'b1;
			line_px[c] = px;
			left_px = px;

			if (cur > brightest_so_far)
				brightest_so_far = cur;
			if (cur < darkest_so_far)
				darkest_so_far = cur;

			if (!last_col) begin
				col = c + 1;
				return;
			end
			if (row_broken)
				asym_rows++;
			row_broken = 1'b0;
			col = 0;
			if (!last_row) begin
				row = r + 1;
				return;
			end
			outcome.brightest = PIXEL_W'(brightest_so_far);
			outcome.darkest = PIXEL_W'(darkest_so_far);
			outcome.asymmetric_rows = asym_rows;
			outcome.contrast_pixels = contrast_total;
			outcome.longest_vertical_run = RUN_W'(longest_run);
			expected_stats.push_back(outcome);
			start_frame();
		endfunction

		task report(string what, longint unsigned got, longint unsigned want);
			$display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
			errors++;
		endtask

		task check_stats(logic [TDATA_OUT_W-1:0] tdata);
			result_t got, want;
			got = result_t'(tdata[STATS_W-1:0]);
			if (tdata[TDATA_OUT_W-1:STATS_W] != 0)
				report("tdata padding", tdata[TDATA_OUT_W-1:STATS_W], 0);
			if (expected_stats.size() == 0) begin
				report("result with no frame pending", 1, 0);
				return;
			end
			want = expected_stats.pop_front();
			frames_checked++;
			if (got.brightest != want.brightest)
				report("brightest", got.brightest, want.brightest);
			if (got.darkest != want.darkest)
				report("darkest", got.darkest, want.darkest);
			if (got.asymmetric_rows != want.asymmetric_rows)
				report("asymmetric_rows", got.asymmetric_rows, want.asymmetric_rows);
			if (got.contrast_pixels != want.contrast_pixels)
				report("contrast_pixels", got.contrast_pixels, want.contrast_pixels);
			if (got.longest_vertical_run != want.longest_vertical_run)
				report("longest_vertical_run", got.longest_vertical_run,
					want.longest_vertical_run);
		endtask
	endclass

endpackage

// File: bench/grayscale_frame_statistics_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grayscale_frame_statistics_test
// Streams frames of random and patterned pixels through the block under
// changing frame sizes and thresholds, with random stalls on both streams,
// and checks every frame result field by field against expected statistics.
// ----------------------------------------------------------------------------
module grayscale_frame_statistics_test;
	import gfs_pkg::*;
	import frame_stats_check_pkg::*;

	typedef enum int {SPREAD, FLAT, MIRROR, STRIPES, EXTREMES} pattern_e;

	localparam int TOTAL_PIXELS  = 950;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 80;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [TDATA_IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	frame_stats_scoreboard stats;
	bit tx_idle;
	bit rx_idle;
	int rx_hold;
	int pixels_sent;

	grayscale_frame_statistics u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			stats.check_stats(m_axis_tdata);
	end

	initial begin : result_sink
		int stall;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (rx_hold > 0)
				stall = rx_hold;
			else
				stall = rx_idle ? $urandom_range(0, 17) : 0;
			rx_hold = 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	initial begin : watchdog
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	task send_pixel(input logic [PIXEL_W-1:0] px);
		int gap;
		gap = tx_idle ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		do @(posedge clk); while (!s_axis_tready);
		stats.absorb_pixel(px);
		pixels_sent++;
		@(negedge clk);
	endtask

	// hold input until every frame result is back, then let the pipeline drain
	task settle();
		s_axis_tvalid <= 1'b0;
		while (stats.expected_stats.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task configure(input logic [9:0] w, input logic [10:0] h, input logic [PIXEL_W-1:0] t);
		logic [CFG_IDX_W-1:0] idx [3];
		logic [CFG_DATA_W-1:0] vals [3];
		idx = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_CONTRAST_THRESHOLD};
		vals = '{CFG_DATA_W'(w), CFG_DATA_W'(h), CFG_DATA_W'(t)};
		for (int i = 0; i < 3; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
			stats.write_reg(idx[i], vals[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task send_frame(input int cols, input int rows, input pattern_e flavor);
		logic [PIXEL_W-1:0] row_px [LINE_DEPTH];
		logic [PIXEL_W-1:0] base;
		bit repeat_row;
		base = PIXEL_W'($urandom_range(0, 255));
		for (int r = 0; r < rows; r++) begin
			repeat_row = r > 0 && $urandom_range(0, 1);
			for (int c = 0; c < cols; c++) begin
				case (flavor)
					SPREAD: row_px[c] = PIXEL_W'($urandom_range(0, 255));
					FLAT: row_px[c] = base;
					MIRROR: begin
						if (!repeat_row) begin
							if (2 * c > cols - 1)
								row_px[c] = row_px[cols - 1 - c];
							else
								row_px[c] = PIXEL_W'($urandom_range(0, 255));
							if ($urandom_range(0, 9) == 0)
								row_px[c] = ~row_px[c];
						end
					end
					STRIPES: row_px[c] = base + PIXEL_W'($urandom_range(0, 1));
					default: row_px[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				endcase
				send_pixel(row_px[c]);
			end
		end
	endtask

	initial begin : stimulus
		logic [PIXEL_W-1:0] grid [9];
		int w_val, h_val, t_val, pick;
		grid = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd7};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data = '0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		rx_hold = 0;
		pixels_sent = 0;
		stats = new();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero width and height act as a single pixel
		configure(10'd0, 11'd0, 8'd0);
		send_pixel(8'd0);
		send_pixel(8'd255);
		settle();
		configure(10'd3, 11'd3, 8'd0);
		foreach (grid[i])
			send_pixel(grid[i]);
		settle();
		configure(10'd1, 11'd4, 8'd255);
		send_pixel(8'd5);
		send_pixel(8'd5);
		send_pixel(8'd5);
		send_pixel(8'd9);
		settle();
		configure(10'd4, 11'd1, 8'd100);
		send_pixel(8'd10);
		send_pixel(8'd200);
		send_pixel(8'd200);
		send_pixel(8'd10);

		// stall the result side while single-pixel frames keep coming
		settle();
		configure(10'd1, 11'd1, PIXEL_W'($urandom_range(0, 255)));
		tx_idle = 1'b0;
		rx_hold = LONG_HOLD;
		repeat (16) send_pixel(PIXEL_W'($urandom_range(0, 255)));

		settle();
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		configure(10'd1023, 11'd1, PIXEL_W'($urandom_range(0, 255)));
		send_frame(stats.cols_in_use(), stats.rows_in_use(), SPREAD);

		while (pixels_sent < TOTAL_PIXELS) begin
			settle();
			pick = $urandom_range(0, 19);
			if (pick == 0)
				w_val = 0;
			else
				w_val = pick < 15 ? $urandom_range(1, 8) : $urandom_range(9, 24);
			h_val = $urandom_range(0, 6);
			pick = $urandom_range(0, 5);
			if (pick == 0)
				t_val = 0;
			else
				t_val = pick == 1 ? 255 : $urandom_range(0, 255);
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			configure(10'(w_val), 11'(h_val), PIXEL_W'(t_val));
			repeat ($urandom_range(1, 3))
				send_frame(stats.cols_in_use(), stats.rows_in_use(),
					pattern_e'($urandom_range(0, 4)));
		end
		settle();

		if (stats.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
